// ===== rtl/core/wetp_pkg.sv =====
// Package for the frame header parser: widths, protocol constants, register
// indexes and the record passed from the byte front end to the verdict stage.
// No dependencies.
`default_nettype none
package wetp_pkg;

	localparam int LEN_BITS = 16;
	localparam int OFF_BITS = ((LEN_BITS > 16) ? LEN_BITS : 16) + 2;
	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	localparam logic [7:0] SNAP_SAP = 8'hAA;
	localparam logic [7:0] ETYPE_HI = 8'h08;
	localparam logic [7:0] ETYPE_LO = 8'h00;
	localparam logic [7:0] TCP_PROTO = 8'd6;
	localparam logic [3:0] QOS_SUBTYPE = 4'd8;
	localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
	localparam logic [1:0] FTYPE_DATA = 2'd2;
	localparam logic [1:0] DS_WDS = 2'd3;
	localparam logic [1:0] DS_TO = 2'd1;
	localparam logic [1:0] DS_FROM = 2'd2;
	localparam int ETH_HDR_BYTES = 14;
	localparam int WIFI_HDR_BYTES = 24;
	localparam int WDS_HDR_BYTES = 30;
	localparam int LLC_BYTES = 8;

	localparam logic [2:0] V_DROP = 3'd0;
	localparam logic [2:0] V_MAC = 3'd1;
	localparam logic [2:0] V_IP = 3'd2;
	localparam logic [2:0] V_TCP = 3'd3;
	localparam logic [2:0] V_HTTP = 3'd4;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_PORT = 1'b1;
	localparam logic [15:0] HTTP_PORT_RST = 16'd80;

	localparam int QDEPTH = 2;
	localparam int OUT_BITS = 240;

	typedef struct packed {
		logic                monitor;
		logic [LEN_BITS-1:0] idx;
		logic [15:0]         rt_len;
		logic [15:0]         fc;
		logic [OFF_BITS-1:0] link_end;
		logic [2:0]          err;
		logic [OFF_BITS-1:0] ip_end;
		logic [OFF_BITS-1:0] tcp_end;
		logic [63:0]         ip_addrs;
		logic [15:0]         ip_extra;
		logic [39:0]         tcp_fields;
		logic [47:0]         src;
		logic [47:0]         dst;
	} frame_rec_t;

endpackage
`default_nettype wire

// ===== rtl/core/wetp_front.sv =====
// Byte front end: walks link, IPv4 and TCP headers one byte per cycle while take
// is high, and emits one frame record on the last byte. Depends on wetp_pkg.
`default_nettype none
module wetp_front import wetp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       monitor,
	input  wire logic       take,
	input  wire logic [7:0] pkt_byte,
	input  wire logic       last_byte,
	output frame_rec_t      rec
);

	logic [LEN_BITS-1:0] cnt_q;
	logic [15:0]         rt_q, rt_n, fc_q, fc_n;
	logic [OFF_BITS-1:0] le_q, le_n, ie_q, ie_n, te_q, te_n;
	logic [2:0]          pp_q, pp_n;
	logic [63:0]         ipf_q, ipf_n;
	logic [15:0]         ipx_q, ipx_n;
	logic [39:0]         tcpf_q, tcpf_n;
	logic [47:0]         addr_q [4];
	logic [47:0]         addr_n [4];

	logic [OFF_BITS-1:0] i18, p18, d, o, t, hdr, i8;
	logic                link_known, sel_ok;
	logic [1:0]          k;
	logic [47:0]         src, dst;

	always_comb begin
		i18 = OFF_BITS'(cnt_q);
		i8 = i18 + OFF_BITS'(LLC_BYTES);
		rt_n = rt_q; fc_n = fc_q; le_n = le_q; pp_n = pp_q;
		ie_n = ie_q; te_n = te_q; ipf_n = ipf_q; ipx_n = ipx_q; tcpf_n = tcpf_q;
		for (int n = 0; n < 4; n++) addr_n[n] = addr_q[n];
		link_known = 1'b0;
		hdr = '0; d = '0; o = '0; t = '0; k = '0; sel_ok = 1'b0;
		if (monitor) begin
			if (cnt_q == LEN_BITS'(2)) rt_n[7:0] = pkt_byte;
			if (cnt_q == LEN_BITS'(3)) rt_n[15:8] = pkt_byte;
			p18 = OFF_BITS'(rt_n);
			if (i18 >= OFF_BITS'(4) && p18 >= OFF_BITS'(4)) begin
				if (i18 == p18) begin
					fc_n[7:0] = pkt_byte;
				end else if (i18 == p18 + OFF_BITS'(1)) begin
					fc_n[15:8] = pkt_byte;
					hdr = (fc_n[9:8] == DS_WDS) ? OFF_BITS'(WDS_HDR_BYTES)
					                            : OFF_BITS'(WIFI_HDR_BYTES);
					if (fc_n[7:4] == QOS_SUBTYPE) hdr = hdr + OFF_BITS'(2);
					le_n = p18 + hdr + OFF_BITS'(LLC_BYTES);
				end
				d = i18 - p18 - OFF_BITS'(4);
				if (i18 >= p18 + OFF_BITS'(4) && i18 < p18 + OFF_BITS'(22)) begin
					k = (d < OFF_BITS'(6)) ? 2'd0 : (d < OFF_BITS'(12)) ? 2'd1 : 2'd2;
					sel_ok = 1'b1;
				end else if (i18 >= p18 + OFF_BITS'(24) && i18 < p18 + OFF_BITS'(30)) begin
					k = 2'd3;
					sel_ok = 1'b1;
				end
				if (i18 >= p18 + OFF_BITS'(2)) begin
					link_known = 1'b1;
					if ((i8 == le_n || i8 == le_n + OFF_BITS'(1)) && pkt_byte != SNAP_SAP)
						pp_n[0] = 1'b1;
					if (i8 == le_n + OFF_BITS'(6) && pkt_byte != ETYPE_HI) pp_n[0] = 1'b1;
					if (i8 == le_n + OFF_BITS'(7) && pkt_byte != ETYPE_LO) pp_n[0] = 1'b1;
				end
			end
		end else begin
			p18 = '0;
			le_n = OFF_BITS'(ETH_HDR_BYTES);
			link_known = 1'b1;
			if (cnt_q < LEN_BITS'(12)) begin
				k = (cnt_q < LEN_BITS'(6)) ? 2'd0 : 2'd1;
				sel_ok = 1'b1;
			end else if (cnt_q == LEN_BITS'(12) && pkt_byte != ETYPE_HI) begin
				pp_n[0] = 1'b1;
			end else if (cnt_q == LEN_BITS'(13) && pkt_byte != ETYPE_LO) begin
				pp_n[0] = 1'b1;
			end
		end
		if (sel_ok) addr_n[k] = {addr_q[k][39:0], pkt_byte};

		if (link_known && i18 >= le_n) begin
			o = i18 - le_n;
			if (o == '0) begin
				ie_n = le_n + OFF_BITS'({pkt_byte[3:0], 2'b00});
				if (pkt_byte[3:0] < MIN_HDR_WORDS) pp_n[1] = 1'b1;
			end else begin
				if (o == OFF_BITS'(8)) ipx_n[15:8] = pkt_byte;
				else if (o == OFF_BITS'(9)) ipx_n[7:0] = pkt_byte;
				else if (o >= OFF_BITS'(12) && o < OFF_BITS'(20))
					ipf_n = {ipf_q[55:0], pkt_byte};
				if (i18 >= ie_q) begin
					t = i18 - ie_q;
					if (t < OFF_BITS'(4)) begin
						tcpf_n[39:8] = {tcpf_q[31:8], pkt_byte};
					end else if (t == OFF_BITS'(12)) begin
						te_n = ie_q + OFF_BITS'({pkt_byte[7:4], 2'b00});
						if (pkt_byte[7:4] < MIN_HDR_WORDS) pp_n[2] = 1'b1;
					end else if (t == OFF_BITS'(13)) begin
						tcpf_n[7:0] = pkt_byte;
					end
				end
			end
		end

		if (monitor) begin
			unique case (fc_n[9:8])
				2'd0:    begin dst = addr_n[0]; src = addr_n[1]; end
				DS_FROM: begin dst = addr_n[0]; src = addr_n[2]; end
				DS_TO:   begin dst = addr_n[2]; src = addr_n[1]; end
				default: begin dst = addr_n[2]; src = addr_n[3]; end
			endcase
		end else begin
			dst = addr_n[0]; src = addr_n[1];
		end

		rec.monitor = monitor;
		rec.idx = cnt_q;
		rec.rt_len = rt_n;
		rec.fc = fc_n;
		rec.link_end = le_n;
		rec.err = pp_n;
		rec.ip_end = ie_n;
		rec.tcp_end = te_n;
		rec.ip_addrs = ipf_n;
		rec.ip_extra = ipx_n;
		rec.tcp_fields = tcpf_n;
		rec.src = src;
		rec.dst = dst;
	end

	always_ff @(posedge clk) begin
		if (take) for (int n = 0; n < 4; n++) addr_q[n] <= addr_n[n];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rt_q <= '0; fc_q <= '0; le_q <= '0; pp_q <= '0;
			ie_q <= '0; te_q <= '0; ipf_q <= '0; ipx_q <= '0; tcpf_q <= '0;
		end else if (take) begin
			if (last_byte) begin
				cnt_q <= '0; rt_q <= '0; fc_q <= '0; le_q <= '0; pp_q <= '0;
				ie_q <= '0; te_q <= '0; ipf_q <= '0; ipx_q <= '0; tcpf_q <= '0;
			end else begin
				if (cnt_q != LEN_MAX) cnt_q <= cnt_q + LEN_BITS'(1);
				rt_q <= rt_n; fc_q <= fc_n; le_q <= le_n; pp_q <= pp_n;
				ie_q <= ie_n; te_q <= te_n; ipf_q <= ipf_n; ipx_q <= ipx_n;
				tcpf_q <= tcpf_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/wetp_queue.sv =====
// Two-entry record queue between the byte front end and the verdict stage.
// Depends on wetp_pkg.
`default_nettype none
module wetp_queue import wetp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire frame_rec_t din,
	output logic      full,
	output logic      nonempty,
	input  wire logic pop,
	output frame_rec_t dout
);

	frame_rec_t mem_q [QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(QDEPTH));
	assign nonempty = (cnt_q != 2'd0);
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDEPTH)) else $error("queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("pop from empty queue");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'(QDEPTH)) |-> (wp_q == rp_q))
		else $error("queue pointers out of step");

endmodule
`default_nettype wire

// ===== rtl/core/wetp_back.sv =====
// Verdict stage: turns a frame record into the result word and holds it in
// the output register. Depends on wetp_pkg.
`default_nettype none
module wetp_back import wetp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] http_port,
	input  wire logic        have,
	input  wire frame_rec_t  rec,
	output logic             pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [OUT_BITS-1:0] m_tdata
);

	logic [OFF_BITS-1:0] L, p, pay_w;
	logic [2:0]  v;
	logic [47:0] src, dst;
	logic [15:0] pay, dport;
	logic        link_ok, ip_ok;
	logic [OUT_BITS-1:0] word;
	logic        vld_q;
	logic [OUT_BITS-1:0] data_q;

	always_comb begin
		L = OFF_BITS'(rec.idx) + OFF_BITS'(1);
		p = OFF_BITS'(rec.rt_len);
		dport = rec.tcp_fields[23:8];
		pay_w = L - rec.tcp_end;
		pay = (pay_w > OFF_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(pay_w);
		v = V_DROP;
		link_ok = 1'b0;
		ip_ok = 1'b0;
		if (rec.idx == LEN_MAX) begin
			v = V_DROP;
		end else if (rec.monitor) begin
			if (!(L < OFF_BITS'(4) || p < OFF_BITS'(4) || p >= L ||
			      p + OFF_BITS'(WIFI_HDR_BYTES) > L) &&
			    rec.fc[3:2] == FTYPE_DATA &&
			    !(rec.fc[9:8] == DS_WDS && p + OFF_BITS'(WDS_HDR_BYTES) > L)) begin
				v = V_MAC;
				link_ok = !(rec.link_end > L || rec.err[0]);
			end
		end else if (L >= OFF_BITS'(ETH_HDR_BYTES)) begin
			v = V_MAC;
			link_ok = !rec.err[0];
		end
		if (link_ok) begin
			if (L < rec.link_end + OFF_BITS'(20) || rec.err[1] || L < rec.ip_end) begin
				v = V_DROP;
			end else begin
				v = V_IP;
				if (rec.ip_extra[7:0] == TCP_PROTO) begin
					if (L < rec.ip_end + OFF_BITS'(20) || rec.err[2] || L < rec.tcp_end) begin
						v = V_DROP;
					end else begin
						ip_ok = 1'b1;
						v = (dport == http_port && pay != 16'd0) ? V_HTTP : V_TCP;
					end
				end
			end
		end
		src = (v == V_DROP) ? 48'd0 : rec.src;
		dst = (v == V_DROP) ? 48'd0 : rec.dst;
		word = '0;
		word[2:0] = v;
		word[50:3] = src;
		word[98:51] = dst;
		if (v >= V_IP) begin
			word[106:99] = rec.ip_extra[7:0];
			word[138:107] = rec.ip_addrs[63:32];
			word[170:139] = rec.ip_addrs[31:0];
			word[178:171] = rec.ip_extra[15:8];
		end
		if (ip_ok) begin
			word[194:179] = rec.tcp_fields[39:24];
			word[210:195] = dport;
			word[218:211] = rec.tcp_fields[7:0];
			word[234:219] = pay;
		end
	end

	assign pop = have && (!vld_q || m_tready);
	assign m_tvalid = vld_q;
	assign m_tdata = data_q;

	always_ff @(posedge clk) begin
		if (pop) data_q <= word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!vld_q || m_tready) begin
			vld_q <= have;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/wifi_eth_ipv4_tcp_header_parser_unit.sv =====
// Frame header parser top level: one byte per cycle in, one verdict word per frame out.
// m_tvalid is registered; it rises when a queued record enters the output register.
// Throughput: one byte per cycle; s_tready drops only when the 2-record queue is full.
// Reset (arst_n low, async): frame state cleared, monitor mode off, http_port 80.
// Address registers are not reset. Depends on wetp_pkg, wetp_front/queue/back.
`default_nettype none
module wifi_eth_ipv4_tcp_header_parser_unit import wetp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // pkt_byte
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// verdict, src_mac, dst_mac, ip_proto, ip_src, ip_dst, ip_ttl,
	// tcp sport, tcp dport, tcp_flags, tcp payload length, zero pad
	output logic [OUT_BITS-1:0] m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic        mode_q;
	logic [15:0] port_q;
	logic        take, full, nonempty, pop;
	frame_rec_t  rec_in, rec_out;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PORT) ? {16'd0, port_q} : {31'd0, mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			port_q <= HTTP_PORT_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_MODE) mode_q <= pwdata[0];
			else port_q <= pwdata[15:0];
		end
	end

	assign s_tready = !full;
	assign take = s_tvalid && s_tready;

	wetp_front u_front (
		.clk(clk), .arst_n(arst_n), .monitor(mode_q), .take(take),
		.pkt_byte(s_tdata), .last_byte(s_tlast), .rec(rec_in)
	);

	wetp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(take && s_tlast), .din(rec_in),
		.full(full), .nonempty(nonempty), .pop(pop), .dout(rec_out)
	);

	wetp_back u_back (
		.clk(clk), .arst_n(arst_n), .http_port(port_q), .have(nonempty),
		.rec(rec_out), .pop(pop), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule
`default_nettype wire

// ===== test/wetp_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the frame header parser: watches the byte stream, the verdict
// stream and register writes, predicts each verdict word and compares it.
// Depends on wetp_pkg.
module wetp_checker import wetp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tlast,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OUT_BITS-1:0] m_tdata,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  pending,
	output int                  errors
);

	localparam int NF = 11;
	localparam int FLSB[NF] = '{0, 3, 51, 99, 107, 139, 171, 179, 195, 211, 219};
	localparam int FW[NF]   = '{3, 48, 48, 8, 32, 32, 8, 16, 16, 8, 16};
	localparam string FNAME[NF] = '{"verdict", "src_mac", "dst_mac", "ip_proto", "ip_src",
		"ip_dst", "ip_ttl", "sport", "dport", "tcp_flags", "pay_len"};
	localparam logic [63:0] MAX_IDX = 64'(LEN_MAX);

	logic        mode;
	logic [15:0] port;
	logic [63:0] cnt, rt_len, fctl, link_end, errf, ip_end, ip_addrs, ip_x, tcp_end, tcp_f;
	logic [63:0] mac[4];
	logic [63:0] fld[NF];
	logic [63:0] src, dst;
	logic [234:0] verdict_q[$];

	task automatic clear_frame();
		cnt = 0; rt_len = 0; fctl = 0; link_end = 0; errf = 0;
		ip_end = 0; ip_addrs = 0; ip_x = 0; tcp_end = 0; tcp_f = 0;
	endtask

	task automatic shift_mac(input logic [63:0] k, input logic [63:0] b);
		mac[k[1:0]] = ((mac[k[1:0]] << 8) | b) & 64'hFFFF_FFFF_FFFF;
	endtask

	task automatic take_upper(input logic [63:0] i, input logic [63:0] b);
		logic [63:0] o, t, ports, dof;
		if (i < link_end)
			return;
		o = i - link_end;
		if (o == 0) begin
			ip_end = link_end + (b & 15) * 4;
			if ((b & 15) < MIN_HDR_WORDS)
				errf |= 2;
			return;
		end
		if (o == 8)
			ip_x = (ip_x & 64'hFF) | (b << 8);
		else if (o == 9)
			ip_x = (ip_x & 64'hFF00) | b;
		else if (o >= 12 && o < 20)
			ip_addrs = (ip_addrs << 8) | b;
		if (i < ip_end)
			return;
		t = i - ip_end;
		if (t < 4) begin
			ports = (((tcp_f >> 8) << 8) | b) & 64'hFFFF_FFFF;
			tcp_f = (ports << 8) | (tcp_f & 64'hFF);
		end else if (t == 12) begin
			dof = (b >> 4) & 15;
			tcp_end = ip_end + dof * 4;
			if (dof < MIN_HDR_WORDS)
				errf |= 4;
		end else if (t == 13) begin
			tcp_f = (tcp_f & ~64'hFF) | b;
		end
	endtask

	// fills fld[3..10], src, dst; returns the verdict
	function automatic logic [2:0] classify(input logic [63:0] i);
		logic [63:0] n, p, ds, pay, dport;
		n = i + 1;
		if (i >= MAX_IDX)
			return V_DROP;
		if (mode) begin
			p = rt_len;
			if (n < 4 || p < 4 || p >= n || p + WIFI_HDR_BYTES > n)
				return V_DROP;
			if (((fctl >> 2) & 3) != 64'(FTYPE_DATA))
				return V_DROP;
			ds = (fctl >> 8) & 3;
			if (ds == 64'(DS_WDS) && p + WDS_HDR_BYTES > n)
				return V_DROP;
			case (ds[1:0])
				2'd0: begin dst = mac[0]; src = mac[1]; end
				DS_FROM: begin dst = mac[0]; src = mac[2]; end
				DS_TO: begin dst = mac[2]; src = mac[1]; end
				default: begin dst = mac[2]; src = mac[3]; end
			endcase
			if (link_end > n || errf[0])
				return V_MAC;
		end else begin
			if (n < ETH_HDR_BYTES)
				return V_DROP;
			dst = mac[0];
			src = mac[1];
			if (errf[0])
				return V_MAC;
		end
		if (n < link_end + 20 || errf[1] || n < ip_end)
			return V_DROP;
		fld[3] = ip_x & 64'hFF;
		fld[4] = ip_addrs >> 32;
		fld[5] = ip_addrs & 64'hFFFF_FFFF;
		fld[6] = (ip_x >> 8) & 64'hFF;
		if (fld[3] != 64'(TCP_PROTO))
			return V_IP;
		if (n < ip_end + 20 || errf[2] || n < tcp_end)
			return V_DROP;
		pay = n - tcp_end;
		dport = (tcp_f >> 8) & 64'hFFFF;
		fld[7] = (tcp_f >> 24) & 64'hFFFF;
		fld[8] = dport;
		fld[9] = tcp_f & 64'hFF;
		fld[10] = pay > 64'hFFFF ? 64'hFFFF : pay;
		return (dport == 64'(port) && pay > 0) ? V_HTTP : V_TCP;
	endfunction

	task automatic parse_byte(input logic [7:0] bin, input logic last);
		logic [63:0] b, i, p, hdr, q;
		logic        known;
		logic [2:0]  v;
		b = 64'(bin);
		i = cnt;
		known = 0;
		if (cnt < MAX_IDX)
			cnt++;
		if (mode) begin
			if (i == 2)
				rt_len = (rt_len & 64'hFF00) | b;
			else if (i == 3)
				rt_len = (rt_len & 64'hFF) | (b << 8);
			p = rt_len;
			if (i >= 4 && p >= 4) begin
				if (i == p) begin
					fctl = (fctl & 64'hFF00) | b;
				end else if (i == p + 1) begin
					fctl = (fctl & 64'hFF) | (b << 8);
					hdr = (((fctl >> 8) & 3) == 64'(DS_WDS)) ? WDS_HDR_BYTES : WIFI_HDR_BYTES;
					if (((fctl >> 4) & 15) == 64'(QOS_SUBTYPE))
						hdr += 2;
					link_end = p + hdr + LLC_BYTES;
				end
				if (i >= p + 4 && i < p + 22)
					shift_mac((i - p - 4) / 6, b);
				else if (i >= p + 24 && i < p + 30)
					shift_mac(3, b);
				if (i >= p + 2) begin
					q = link_end - LLC_BYTES;
					known = 1;
					if ((i == q || i == q + 1) && bin != SNAP_SAP)
						errf |= 1;
					if (i == q + 6 && bin != ETYPE_HI)
						errf |= 1;
					if (i == q + 7 && bin != ETYPE_LO)
						errf |= 1;
				end
			end
		end else begin
			link_end = ETH_HDR_BYTES;
			known = 1;
			if (i < 12)
				shift_mac(i / 6, b);
			else if (i == 12 && bin != ETYPE_HI)
				errf |= 1;
			else if (i == 13 && bin != ETYPE_LO)
				errf |= 1;
		end
		if (known)
			take_upper(i, b);
		if (!last)
			return;
		for (int k = 0; k < NF; k++)
			fld[k] = 0;
		src = 0;
		dst = 0;
		v = classify(i);
		if (v == V_DROP) begin
			for (int k = 0; k < NF; k++)
				fld[k] = 0;
		end else begin
			fld[1] = src & 64'hFFFF_FFFF_FFFF;
			fld[2] = dst & 64'hFFFF_FFFF_FFFF;
		end
		fld[0] = 64'(v);
		verdict_q.push_back({fld[10][15:0], fld[9][7:0], fld[8][15:0], fld[7][15:0],
			fld[6][7:0], fld[5][31:0], fld[4][31:0], fld[3][7:0], fld[2][47:0],
			fld[1][47:0], fld[0][2:0]});
		clear_frame();
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [234:0] want;
		logic [63:0]  e, a, msk;
		if (!arst_n) begin
			mode = 0;
			port = HTTP_PORT_RST;
			for (int k = 0; k < 4; k++)
				mac[k] = 0;
			clear_frame();
			verdict_q.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_MODE)
					mode = pwdata[0];
				else
					port = pwdata[15:0];
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected verdict word %h", m_tdata);
					errors++;
				end else begin
					want = verdict_q.pop_front();
					for (int k = 0; k < NF; k++) begin
						msk = (64'd1 << FW[k]) - 1;
						e = 64'(want >> FLSB[k]) & msk;
						a = 64'(m_tdata >> FLSB[k]) & msk;
						if (e != a) begin
							if (errors < 10)
								$display("%s mismatch: expected %h, got %h", FNAME[k], e, a);
							errors++;
						end
					end
				end
			end
		end
		pending = verdict_q.size();
	end

endmodule

// ===== test/tb_wifi_eth_ipv4_tcp_header_parser_unit.sv =====
`timescale 1ns / 100ps
// Top of the frame header parser testbench: clock, reset, register writes,
// frame stimulus and verdict-side back-pressure; checking is in wetp_checker.
// Depends on wetp_pkg, wetp_checker and the parser RTL.
module tb_wifi_eth_ipv4_tcp_header_parser_unit;
	import wetp_pkg::*;

	localparam int LIMIT = 200000;

	logic                clk, arst_n;
	logic                s_tvalid, s_tready, s_tlast;
	logic [7:0]          s_tdata;
	logic                m_tvalid, m_tready;
	logic [OUT_BITS-1:0] m_tdata;
	logic                psel, penable, pwrite, pready;
	logic [2:0]          paddr;
	logic [31:0]         pwdata, prdata;
	int                  pending, errors, cycles, rx_wait;
	logic                quiet, rx_hold;
	logic [15:0]         cur_port;
	logic [7:0]          frm[$];

	wifi_eth_ipv4_tcp_header_parser_unit i_dut (.*);

	wetp_checker i_chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// verdict side: random gap per word, one long hold-off on request
	always @(negedge clk) begin
		if (rx_hold) begin
			m_tready <= 0;
			repeat (600) @(negedge clk);
			rx_hold = 0;
		end else if (rx_wait > 0) begin
			m_tready <= 0;
			rx_wait--;
		end else begin
			m_tready <= 1;
		end
	end

	always @(posedge clk)
		if (m_tvalid && m_tready)
			rx_wait = quiet ? 0 : $urandom_range(0, 7);

	task automatic reg_write(input logic idx, input logic [31:0] val);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_PORT)
			cur_port = val[15:0];
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic send_frame();
		int g;
		for (int k = 0; k < frm.size(); k++) begin
			g = quiet ? 0 : $urandom_range(0, 7);
			if (g != 0) begin
				s_tvalid <= 0;
				repeat (g) @(negedge clk);
			end
			s_tvalid <= 1;
			s_tdata <= frm[k];
			s_tlast <= (k == frm.size() - 1);
			do @(posedge clk); while (!s_tready);
			@(negedge clk);
		end
		s_tvalid = 0;
	endtask

	task automatic rnd_bytes(input int n);
		for (int k = 0; k < n; k++)
			frm.push_back(8'($urandom));
	endtask

	// builds one frame; bad_link spoils one LLC or ethertype byte, cut > 0 truncates
	task automatic make_frame(input logic mon, input logic [1:0] ds, input logic qos,
		input logic data_fr, input logic bad_link, input int ihl, input logic [7:0] proto,
		input int doff, input logic http, input int pay, input int cut);
		int p, hdr, pos;
		frm.delete();
		if (mon) begin
			p = $urandom_range(4, 10);
			frm.push_back(8'($urandom));
			frm.push_back(8'($urandom));
			frm.push_back(8'(p));
			frm.push_back(8'(p >> 8));
			rnd_bytes(p - 4);
			frm.push_back({qos ? QOS_SUBTYPE : 4'($urandom_range(0, 7)),
				data_fr ? FTYPE_DATA : 2'($urandom_range(0, 1) * 3), 2'($urandom)});
			frm.push_back({6'($urandom), ds});
			hdr = (ds == DS_WDS ? WDS_HDR_BYTES : WIFI_HDR_BYTES) + (qos ? 2 : 0);
			rnd_bytes(hdr - 2);
			pos = frm.size();
			frm.push_back(SNAP_SAP);
			frm.push_back(SNAP_SAP);
			frm.push_back(8'h03);
			rnd_bytes(3);
			frm.push_back(ETYPE_HI);
			frm.push_back(ETYPE_LO);
			if (bad_link) begin
				case ($urandom_range(0, 3))
					0: frm[pos] ^= 8'($urandom_range(1, 255));
					1: frm[pos + 1] ^= 8'($urandom_range(1, 255));
					2: frm[pos + 6] ^= 8'($urandom_range(1, 255));
					default: frm[pos + 7] ^= 8'($urandom_range(1, 255));
				endcase
			end
		end else begin
			rnd_bytes(12);
			pos = frm.size();
			frm.push_back(ETYPE_HI);
			frm.push_back(ETYPE_LO);
			if (bad_link)
				frm[pos + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
		end
		pos = frm.size();
		frm.push_back({4'd4, 4'(ihl)});
		rnd_bytes(19);
		frm[pos + 9] = proto;
		if (ihl > 5)
			rnd_bytes((ihl - 5) * 4);
		if (proto == TCP_PROTO) begin
			pos = frm.size();
			rnd_bytes(20);
			if (http) begin
				frm[pos + 2] = cur_port[15:8];
				frm[pos + 3] = cur_port[7:0];
			end
			frm[pos + 12] = {4'(doff), 4'($urandom)};
			if (doff > 5)
				rnd_bytes((doff - 5) * 4);
		end
		rnd_bytes(pay);
		while (cut > 0 && frm.size() > cut)
			void'(frm.pop_back());
	endtask

	task automatic rand_frame(input logic mon);
		int ihl, doff;
		logic [7:0] proto;
		if ($urandom_range(0, 99) < 15) begin
			frm.delete();
			rnd_bytes($urandom_range(1, 40));
			if (mon && $urandom_range(0, 1))
				frm[0] = 8'($urandom);
			return;
		end
		ihl = $urandom_range(0, 4) == 0 ? $urandom_range(0, 4) : $urandom_range(5, 6);
		doff = $urandom_range(0, 4) == 0 ? $urandom_range(0, 4) : $urandom_range(5, 6);
		proto = $urandom_range(0, 2) == 0 ? 8'($urandom) : TCP_PROTO;
		make_frame(mon, 2'($urandom), $urandom_range(0, 2) == 0, $urandom_range(0, 9) != 0,
			$urandom_range(0, 9) == 0, ihl, proto, doff, $urandom_range(0, 9) < 4,
			$urandom_range(0, 6), $urandom_range(0, 9) == 0 ? $urandom_range(1, 60) : 0);
	endtask

	// ph 1: long receiver hold-off over back-to-back frames; ph 2: sender drains midway
	task automatic rand_phase(input logic mon, input logic [15:0] prt, input int ph);
		int nf;
		wait_idle();
		reg_write(REG_PORT, {16'($urandom), prt});
		reg_write(REG_MODE, {31'($urandom), mon});
		nf = 0;
		while (nf < 4) begin
			if (ph == 1 && nf == 0)
				rx_hold = 1;
			quiet = rx_hold;
			if (ph == 2 && nf == 2)
				while (pending != 0)
					@(negedge clk);
			rand_frame(mon);
			send_frame();
			nf++;
		end
		quiet = 0;
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0; s_tdata = 0; s_tlast = 0; m_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		cycles = 0; rx_wait = 0; quiet = 0; rx_hold = 0;
		cur_port = HTTP_PORT_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Ethernet: short, bad ethertype, UDP, TCP, HTTP, HTTP without payload,
		// IHL and data offset below 5, truncated IPv4
		frm.delete(); rnd_bytes(13); send_frame();
		make_frame(0, 0, 0, 1, 1, 5, TCP_PROTO, 5, 0, 0, 20); send_frame();
		make_frame(0, 0, 0, 1, 0, 5, 8'd17, 5, 0, 3, 0); send_frame();
		make_frame(0, 0, 0, 1, 0, 6, TCP_PROTO, 6, 0, 2, 0); send_frame();
		make_frame(0, 0, 0, 1, 0, 5, TCP_PROTO, 5, 1, 4, 0); send_frame();
		make_frame(0, 0, 0, 1, 0, 5, TCP_PROTO, 5, 1, 0, 0); send_frame();
		make_frame(0, 0, 0, 1, 0, 4, TCP_PROTO, 5, 0, 2, 0); send_frame();
		make_frame(0, 0, 0, 1, 0, 5, TCP_PROTO, 3, 0, 2, 0); send_frame();
		make_frame(0, 0, 0, 1, 0, 5, TCP_PROTO, 5, 0, 0, 25); send_frame();

		wait_idle();
		reg_write(REG_PORT, 32'hFFFF);
		reg_write(REG_MODE, 32'h1);
		// 802.11: tiny frame, bad radiotap length, non-data, all DS cases, short WDS,
		// QoS, bad LLC, radiotap length past the frame
		frm.delete(); rnd_bytes(3); send_frame();
		frm.delete(); rnd_bytes(12); frm[2] = 8'd3; frm[3] = 8'd0; send_frame();
		make_frame(1, 0, 0, 0, 0, 5, TCP_PROTO, 5, 0, 1, 40); send_frame();
		make_frame(1, 0, 0, 1, 0, 5, TCP_PROTO, 5, 1, 2, 0); send_frame();
		make_frame(1, 1, 0, 1, 0, 5, 8'd1, 5, 0, 0, 0); send_frame();
		make_frame(1, 2, 1, 1, 0, 5, TCP_PROTO, 5, 0, 1, 0); send_frame();
		make_frame(1, 3, 1, 1, 0, 6, TCP_PROTO, 6, 1, 3, 0); send_frame();
		make_frame(1, 3, 0, 1, 0, 5, TCP_PROTO, 5, 0, 0, 34); send_frame();
		make_frame(1, 0, 0, 1, 1, 5, TCP_PROTO, 5, 0, 0, 50); send_frame();
		frm.delete(); rnd_bytes(12); frm[2] = 8'd200; frm[3] = 8'd0; send_frame();

		rand_phase(1, 16'hFFFF, 1);
		rand_phase(0, 16'($urandom), 2);

		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/wetp_pkg.sv
rtl/core/wetp_front.sv
rtl/core/wetp_queue.sv
rtl/core/wetp_back.sv
rtl/core/wifi_eth_ipv4_tcp_header_parser_unit.sv
test/wetp_checker.sv
test/tb_wifi_eth_ipv4_tcp_header_parser_unit.sv
